@@ rtl/core/htt_pkg.sv @@
// Shared types and constants for the heading turn and track controller.
// No dependencies; imported by every module of the block.
package htt_pkg;

  localparam int HEADING_W  = 9;
  localparam int ERR_W      = 10;
  localparam int GAIN_W     = 8;
  localparam int LIMIT_W    = 9;
  localparam int BAND_W     = 9;
  localparam int TOL_W      = 8;
  localparam int SPEED_W    = 10;
  localparam int DUTY_W     = 11;
  localparam int CORR_W     = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int PD_W       = 21;

  localparam int DEFAULT_WINDOW_DEPTH = 8;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CORR_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_BAND = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_TOL      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED     = 3'd6;

  localparam logic [GAIN_W-1:0]  RST_PROP_GAIN     = 8'd125;
  localparam logic [GAIN_W-1:0]  RST_INTEGRAL_GAIN = 8'd1;
  localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN    = 8'd3;
  localparam logic [LIMIT_W-1:0] RST_CORR_LIMIT    = 9'd412;
  localparam logic [BAND_W-1:0]  RST_INTEGRAL_BAND = 9'd15;
  localparam logic [TOL_W-1:0]   RST_TURN_TOL      = 8'd2;
  localparam logic [SPEED_W-1:0] RST_MIN_SPEED     = 10'd512;

  localparam logic signed [ERR_W-1:0] FULL_CIRCLE = 10'sd360;
  localparam logic signed [ERR_W-1:0] HALF_CIRCLE = 10'sd180;
  localparam logic [DUTY_W-1:0] LEFT_BOOST  = 11'd512;
  localparam logic [DUTY_W-1:0] RIGHT_BOOST = 11'd450;

  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  integral_gain_tenths;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [LIMIT_W-1:0] correction_limit;
    logic [BAND_W-1:0]  integral_band;
    logic [TOL_W-1:0]   turn_tolerance;
    logic [SPEED_W-1:0] min_speed;
  } htt_cfg_t;

  typedef struct packed {
    logic command;
    logic aligned;
    logic turn_left;
  } htt_ctrl_t;

endpackage

@@ rtl/core/htt_cfg.sv @@
// Configuration register file of the heading controller.
// Depends on htt_pkg.
module htt_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [htt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [htt_pkg::CFG_DATA_W-1:0] cfg_data,
  output htt_pkg::htt_cfg_t              cfg
);
  import htt_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain            <= RST_PROP_GAIN;
      cfg.integral_gain_tenths <= RST_INTEGRAL_GAIN;
      cfg.deriv_gain           <= RST_DERIV_GAIN;
      cfg.correction_limit     <= RST_CORR_LIMIT;
      cfg.integral_band        <= RST_INTEGRAL_BAND;
      cfg.turn_tolerance       <= RST_TURN_TOL;
      cfg.min_speed            <= RST_MIN_SPEED;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PROP_GAIN:     cfg.prop_gain            <= cfg_data[GAIN_W-1:0];
        REG_INTEGRAL_GAIN: cfg.integral_gain_tenths <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:    cfg.deriv_gain           <= cfg_data[GAIN_W-1:0];
        REG_CORR_LIMIT:    cfg.correction_limit     <= cfg_data[LIMIT_W-1:0];
        REG_INTEGRAL_BAND: cfg.integral_band        <= cfg_data[BAND_W-1:0];
        REG_TURN_TOL:      cfg.turn_tolerance       <= cfg_data[TOL_W-1:0];
        REG_MIN_SPEED:     cfg.min_speed            <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/htt_err.sv @@
// Error stage: heading error, side select, error window with running sum,
// and the gain products. Depends on htt_pkg.
module htt_err #(
  parameter int WINDOW_DEPTH = htt_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  logic                                command,
  input  logic [htt_pkg::HEADING_W-1:0]       target_heading,
  input  logic [htt_pkg::HEADING_W-1:0]       current_heading,
  input  htt_pkg::htt_cfg_t                   cfg,
  output htt_pkg::htt_ctrl_t                  ctrl,
  output logic signed [htt_pkg::PD_W-1:0]     pd_term,
  output logic signed [htt_pkg::ERR_W+$clog2(WINDOW_DEPTH)+htt_pkg::GAIN_W:0] int_term
);
  import htt_pkg::*;

  localparam int SUM_W = ERR_W + $clog2(WINDOW_DEPTH);
  localparam int INT_W = SUM_W + GAIN_W + 1;

  logic signed [ERR_W-1:0]  window [WINDOW_DEPTH];
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_next;
  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  err_clip;
  logic signed [ERR_W-1:0]  err_wrap;
  logic [HEADING_W-1:0]     err_mag;
  logic                     err_neg;
  logic                     turn_left;
  logic                     track_left;
  logic                     in_band;
  logic signed [ERR_W:0]    delta;
  logic signed [SUM_W-1:0]  sum_used;
  logic signed [18:0]       prop_prod;
  logic signed [19:0]       deriv_prod;
  htt_ctrl_t                ctrl_next;

  always_comb begin
    err      = $signed({1'b0, target_heading}) - $signed({1'b0, current_heading});
    err_neg  = err[ERR_W-1];
    err_clip = err_neg ? -10'sd1 : err;
    err_wrap = err_neg ? err + FULL_CIRCLE : err;
    err_mag  = err_neg ? HEADING_W'(-err) : err[HEADING_W-1:0];

    turn_left  = err_wrap[ERR_W-1] || (err_wrap >= HALF_CIRCLE);
    track_left = err_neg || (err >= HALF_CIRCLE);

    sum_next = sum + SUM_W'(err_clip) - SUM_W'(window[WINDOW_DEPTH-1]);
    delta    = (ERR_W+1)'(err_clip) - (ERR_W+1)'(window[WINDOW_DEPTH-2]);
    in_band  = err_neg ? (cfg.integral_band != '0) : (err[BAND_W-1:0] <= cfg.integral_band);
    sum_used = in_band ? sum_next : '0;

    prop_prod  = 19'($signed({1'b0, cfg.prop_gain})) * 19'(err_clip);
    deriv_prod = 20'($signed({1'b0, cfg.deriv_gain})) * 20'(delta);

    ctrl_next.command   = command;
    ctrl_next.aligned   = !command && ({1'b0, err_mag} < {2'b0, cfg.turn_tolerance});
    ctrl_next.turn_left = command ? track_left : turn_left;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        window[i] <= '0;
      end
      sum <= '0;
    end else if (advance && command) begin
      window[0] <= err_clip;
      for (int i = 1; i < WINDOW_DEPTH; i++) begin
        window[i] <= window[i-1];
      end
      sum <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ctrl     <= ctrl_next;
      pd_term  <= PD_W'(prop_prod) + PD_W'(deriv_prod);
      int_term <= INT_W'($signed({1'b0, cfg.integral_gain_tenths})) * INT_W'(sum_used);
    end
  end

endmodule

@@ rtl/core/htt_drv.sv @@
// Drive stage: scaled correction, clamp, and the four motor duties into
// the result register. Depends on htt_pkg.
module htt_drv #(
  parameter int WINDOW_DEPTH = htt_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  logic                                clk,
  input  logic                                advance,
  input  htt_pkg::htt_ctrl_t                  ctrl,
  input  logic signed [htt_pkg::PD_W-1:0]     pd_term,
  input  logic signed [htt_pkg::ERR_W+$clog2(WINDOW_DEPTH)+htt_pkg::GAIN_W:0] int_term,
  input  htt_pkg::htt_cfg_t                   cfg,
  output logic                                drive_update,
  output logic                                aligned,
  output logic                                turn_left,
  output logic [htt_pkg::DUTY_W-1:0]          left_duty_a,
  output logic [htt_pkg::DUTY_W-1:0]          left_duty_b,
  output logic [htt_pkg::DUTY_W-1:0]          right_duty_a,
  output logic [htt_pkg::DUTY_W-1:0]          right_duty_b,
  output logic [htt_pkg::CORR_W-1:0]          correction
);
  import htt_pkg::*;

  localparam int INT_W  = ERR_W + $clog2(WINDOW_DEPTH) + GAIN_W + 1;
  localparam int ACC_W  = ((PD_W + 4) > INT_W ? (PD_W + 4) : INT_W) + 1;
  localparam int QIN_W  = 13;
  localparam int QSHIFT = 16;
  localparam logic [QIN_W+11:0] RECIP_TEN = 25'd6554;

  logic signed [ACC_W-1:0] pd_ext;
  logic signed [ACC_W-1:0] acc;
  logic [LIMIT_W:0]        limit_p1;
  logic [QIN_W-1:0]        limit_x10;
  logic                    acc_pos;
  logic                    acc_big;
  logic [QIN_W+11:0]       q_prod;
  logic [CORR_W-1:0]       corr;
  logic [DUTY_W-1:0]       duty_l;
  logic [DUTY_W-1:0]       duty_r;
  logic signed [DUTY_W:0]  diff_l;
  logic signed [DUTY_W:0]  diff_r;
  logic [DUTY_W-1:0]       trim_l;
  logic [DUTY_W-1:0]       trim_r;
  logic                    drive_next;
  logic [DUTY_W-1:0]       la_next;
  logic [DUTY_W-1:0]       lb_next;
  logic [DUTY_W-1:0]       ra_next;
  logic [DUTY_W-1:0]       rb_next;
  logic [CORR_W-1:0]       corr_next;

  always_comb begin
    pd_ext    = ACC_W'(pd_term);
    acc       = (pd_ext <<< 3) + (pd_ext <<< 1) + ACC_W'(int_term);
    limit_p1  = {1'b0, cfg.correction_limit} + 10'd1;
    limit_x10 = (QIN_W'(limit_p1) << 3) + (QIN_W'(limit_p1) << 1);
    acc_pos   = !acc[ACC_W-1] && (acc != '0);
    acc_big   = (|acc[ACC_W-2:QIN_W]) || (acc[QIN_W-1:0] >= limit_x10);
    q_prod    = (QIN_W+12)'(acc[QIN_W-1:0]) * RECIP_TEN;
    if (!acc_pos) begin
      corr = '0;
    end else if (acc_big) begin
      corr = cfg.correction_limit;
    end else begin
      corr = q_prod[QSHIFT+CORR_W-1:QSHIFT];
    end

    duty_l = {1'b0, cfg.min_speed} + LEFT_BOOST;
    duty_r = {1'b0, cfg.min_speed} + RIGHT_BOOST;
    diff_l = $signed({1'b0, duty_l}) - $signed({3'b0, corr});
    diff_r = $signed({1'b0, duty_r}) - $signed({3'b0, corr});
    trim_l = diff_l[DUTY_W] ? '0 : diff_l[DUTY_W-1:0];
    trim_r = diff_r[DUTY_W] ? '0 : diff_r[DUTY_W-1:0];

    drive_next = 1'b0;
    la_next    = '0;
    lb_next    = '0;
    ra_next    = '0;
    rb_next    = '0;
    corr_next  = '0;
    if (ctrl.command) begin
      drive_next = 1'b1;
      corr_next  = corr;
      if (ctrl.turn_left) begin
        ra_next = duty_r;
        lb_next = trim_l;
      end else begin
        ra_next = trim_r;
        lb_next = duty_l;
      end
    end else if (!ctrl.aligned) begin
      drive_next = 1'b1;
      if (ctrl.turn_left) begin
        la_next = duty_l;
        ra_next = duty_r;
      end else begin
        lb_next = duty_l;
        rb_next = duty_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive_update <= drive_next;
      aligned      <= ctrl.aligned;
      turn_left    <= ctrl.turn_left;
      left_duty_a  <= la_next;
      left_duty_b  <= lb_next;
      right_duty_a <= ra_next;
      right_duty_b <= rb_next;
      correction   <= corr_next;
    end
  end

endmodule

@@ rtl/core/heading_turn_and_track_pid_top.sv @@
// Top level of the heading turn and track controller: input register,
// error stage, drive stage. Depends on htt_pkg, htt_cfg, htt_err, htt_drv.
//
//   channel  handshake             payload
//   in       in_valid / in_stall   command, target_heading, current_heading
//   out      out_valid / out_stall drive_update, aligned, turn_left, duties, correction
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One transaction per cycle sustained while out_stall is low; a result passes through
// the input register, then the error stage, then the result register before it is offered.
// Synchronous reset clears the valid bits and the error window and loads the configuration defaults.
// A stall on the output fills the three stages before in_stall rises.
// Configuration writes are always taken, cfg_ready is tied high.
module heading_turn_and_track_pid_top #(
  parameter int WINDOW_DEPTH = htt_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            command,
  input  logic [htt_pkg::HEADING_W-1:0]   target_heading,
  input  logic [htt_pkg::HEADING_W-1:0]   current_heading,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            drive_update,
  output logic                            aligned,
  output logic                            turn_left,
  output logic [htt_pkg::DUTY_W-1:0]      left_duty_a,
  output logic [htt_pkg::DUTY_W-1:0]      left_duty_b,
  output logic [htt_pkg::DUTY_W-1:0]      right_duty_a,
  output logic [htt_pkg::DUTY_W-1:0]      right_duty_b,
  output logic [htt_pkg::CORR_W-1:0]      correction,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [htt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [htt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import htt_pkg::*;

  localparam int INT_W = ERR_W + $clog2(WINDOW_DEPTH) + GAIN_W + 1;

  htt_cfg_t                cfg;
  htt_ctrl_t               ctrl;
  logic signed [PD_W-1:0]  pd_term;
  logic signed [INT_W-1:0] int_term;

  logic                    in_vld;
  logic                    in_cmd;
  logic [HEADING_W-1:0]    in_tgt;
  logic [HEADING_W-1:0]    in_cur;
  logic                    mid_vld;
  logic                    ld_out;
  logic                    ld_mid;
  logic                    ld_in;

  assign ld_out    = !out_valid || !out_stall;
  assign ld_mid    = !mid_vld || ld_out;
  assign ld_in     = !in_vld || ld_mid;
  assign in_stall  = !ld_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld    <= 1'b0;
      mid_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ld_in) begin
        in_vld <= in_valid;
      end
      if (ld_mid) begin
        mid_vld <= in_vld;
      end
      if (ld_out) begin
        out_valid <= mid_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ld_in) begin
      in_cmd <= command;
      in_tgt <= target_heading;
      in_cur <= current_heading;
    end
  end

  htt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  htt_err #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_err (
    .clk             (clk),
    .rst             (rst),
    .advance         (in_vld && ld_mid),
    .command         (in_cmd),
    .target_heading  (in_tgt),
    .current_heading (in_cur),
    .cfg             (cfg),
    .ctrl            (ctrl),
    .pd_term         (pd_term),
    .int_term        (int_term)
  );

  htt_drv #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_drv (
    .clk          (clk),
    .advance      (mid_vld && ld_out),
    .ctrl         (ctrl),
    .pd_term      (pd_term),
    .int_term     (int_term),
    .cfg          (cfg),
    .drive_update (drive_update),
    .aligned      (aligned),
    .turn_left    (turn_left),
    .left_duty_a  (left_duty_a),
    .left_duty_b  (left_duty_b),
    .right_duty_a (right_duty_a),
    .right_duty_b (right_duty_b),
    .correction   (correction)
  );

endmodule

@@ tb/tb_heading_turn_and_track_pid_top.sv @@
`timescale 1ns / 100ps
// Testbench for heading_turn_and_track_pid_top: pivot turn and PID heading track
// transactions with random idling on both channels, each result checked per field
// against a local model of the controller. Depends on htt_pkg and heading_turn_and_track_pid_top.
module tb_heading_turn_and_track_pid_top;
  import htt_pkg::*;

  localparam int WIN_DEPTH    = DEFAULT_WINDOW_DEPTH;
  localparam int IDLE_PCT     = 26;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int BATCH_ITEMS  = 90;
  localparam int LAST_PHASE   = 6;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum logic {
    CMD_TURN  = 1'b0,
    CMD_TRACK = 1'b1
  } heading_cmd_e;

  typedef struct {
    heading_cmd_e          cmd;
    logic [HEADING_W-1:0]  target;
    logic [HEADING_W-1:0]  heading;
  } heading_req_t;

  typedef struct packed {
    logic              drive_update;
    logic              aligned;
    logic              turn_left;
    logic [DUTY_W-1:0] left_a;
    logic [DUTY_W-1:0] left_b;
    logic [DUTY_W-1:0] right_a;
    logic [DUTY_W-1:0] right_b;
    logic [CORR_W-1:0] correction;
  } drive_cmd_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  command = 1'b0;
  logic [HEADING_W-1:0]  target_heading = '0;
  logic [HEADING_W-1:0]  current_heading = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  drive_update;
  logic                  aligned;
  logic                  turn_left;
  logic [DUTY_W-1:0]     left_duty_a;
  logic [DUTY_W-1:0]     left_duty_b;
  logic [DUTY_W-1:0]     right_duty_a;
  logic [DUTY_W-1:0]     right_duty_b;
  logic [CORR_W-1:0]     correction;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  heading_req_t            pending_reqs[$];
  drive_cmd_t              expected_drive[$];
  heading_req_t            active_req;
  drive_cmd_t              next_drive;
  htt_cfg_t                ctrl_cfg;
  logic signed [ERR_W-1:0] err_window [WIN_DEPTH];
  bit                      steady_flow = 1'b0;
  int                      errors = 0;
  int                      turns_sent = 0;
  int                      tracks_sent = 0;
  int                      aligned_seen = 0;
  int                      left_seen = 0;
  int                      results_checked = 0;
  int                      settings_used = 1;
  int                      quiet_cycles = 0;

  heading_turn_and_track_pid_top dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .target_heading  (target_heading),
    .current_heading (current_heading),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .drive_update    (drive_update),
    .aligned         (aligned),
    .turn_left       (turn_left),
    .left_duty_a     (left_duty_a),
    .left_duty_b     (left_duty_b),
    .right_duty_a    (right_duty_a),
    .right_duty_b    (right_duty_b),
    .correction      (correction),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [DUTY_W-1:0] clip_duty(int v);
    return (v < 0) ? '0 : DUTY_W'(v);
  endfunction

  function automatic drive_cmd_t predict_drive(heading_req_t req);
    drive_cmd_t r;
    int         err;
    int         wrapped;
    int         mag;
    int         clipped;
    int         sum;
    int         deriv;
    int         base;
    int         band;
    int         i;
    longint     acc;
    longint     corr;
    r = '0;
    err = int'(req.target) - int'(req.heading);
    base = int'(ctrl_cfg.min_speed);
    if (req.cmd == CMD_TURN) begin
      wrapped = (err < 0) ? err + 360 : err;
      mag = (err < 0) ? -err : err;
      r.turn_left = (wrapped < 0 || wrapped >= 180);
      if (mag < int'(ctrl_cfg.turn_tolerance)) begin
        r.aligned = 1'b1;
      end else begin
        r.drive_update = 1'b1;
        if (r.turn_left) begin
          r.left_a = clip_duty(base + 512);
          r.right_a = clip_duty(base + 450);
        end else begin
          r.left_b = clip_duty(base + 512);
          r.right_b = clip_duty(base + 450);
        end
      end
    end else begin
      // collapse negative error, then shift it into the window
      clipped = (err < 0) ? -1 : err;
      r.turn_left = (clipped < 0 || clipped >= 180);
      for (i = WIN_DEPTH - 1; i > 0; i--) begin
        err_window[i] = err_window[i - 1];
      end
      err_window[0] = ERR_W'(clipped);
      sum = 0;
      band = int'(ctrl_cfg.integral_band);
      if (clipped >= -band && clipped <= band) begin
        for (i = 0; i < WIN_DEPTH; i++) begin
          sum += int'(err_window[i]);
        end
      end
      deriv = int'(err_window[0]) - int'(err_window[WIN_DEPTH - 1]);
      acc = 10 * (longint'(ctrl_cfg.prop_gain) * clipped
                  + longint'(ctrl_cfg.deriv_gain) * deriv)
            + longint'(ctrl_cfg.integral_gain_tenths) * sum;
      corr = acc / 10;
      if (corr > longint'(ctrl_cfg.correction_limit)) begin
        corr = longint'(ctrl_cfg.correction_limit);
      end
      if (corr < 0) begin
        corr = 0;
      end
      r.correction = CORR_W'(corr);
      r.drive_update = 1'b1;
      if (r.turn_left) begin
        r.right_a = clip_duty(base + 450);
        r.left_b = clip_duty(base + 512 - int'(corr));
      end else begin
        r.right_a = clip_duty(base + 450 - int'(corr));
        r.left_b = clip_duty(base + 512);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_drive();
    drive_cmd_t got;
    drive_cmd_t want;
    got = '{drive_update, aligned, turn_left, left_duty_a, left_duty_b,
            right_duty_a, right_duty_b, correction};
    if (expected_drive.size() == 0) begin
      report_mismatch("result transaction with nothing expected");
      return;
    end
    want = expected_drive.pop_front();
    results_checked++;
    if (got.drive_update !== want.drive_update)
      report_mismatch($sformatf("drive_update %0d, expected %0d",
                                got.drive_update, want.drive_update));
    if (got.aligned !== want.aligned)
      report_mismatch($sformatf("aligned %0d, expected %0d", got.aligned, want.aligned));
    if (got.turn_left !== want.turn_left)
      report_mismatch($sformatf("turn_left %0d, expected %0d", got.turn_left, want.turn_left));
    if (got.left_a !== want.left_a)
      report_mismatch($sformatf("left_duty_a %0d, expected %0d", got.left_a, want.left_a));
    if (got.left_b !== want.left_b)
      report_mismatch($sformatf("left_duty_b %0d, expected %0d", got.left_b, want.left_b));
    if (got.right_a !== want.right_a)
      report_mismatch($sformatf("right_duty_a %0d, expected %0d", got.right_a, want.right_a));
    if (got.right_b !== want.right_b)
      report_mismatch($sformatf("right_duty_b %0d, expected %0d", got.right_b, want.right_b));
    if (got.correction !== want.correction)
      report_mismatch($sformatf("correction %0d, expected %0d",
                                got.correction, want.correction));
  endtask

  // driver: hold a stalled transaction, predict on acceptance, idle at random
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        next_drive = predict_drive(active_req);
        expected_drive.push_back(next_drive);
        if (active_req.cmd == CMD_TURN) turns_sent++;
        else tracks_sent++;
        if (next_drive.aligned) aligned_seen++;
        if (next_drive.turn_left) left_seen++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
          active_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          command <= active_req.cmd;
          target_heading <= active_req.target;
          current_heading <= active_req.heading;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) check_drive();
      out_stall <= !steady_flow && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb_heading_turn_and_track_pid_top: FAIL");
    $finish;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PROP_GAIN:     ctrl_cfg.prop_gain = GAIN_W'(val);
      REG_INTEGRAL_GAIN: ctrl_cfg.integral_gain_tenths = GAIN_W'(val);
      REG_DERIV_GAIN:    ctrl_cfg.deriv_gain = GAIN_W'(val);
      REG_CORR_LIMIT:    ctrl_cfg.correction_limit = LIMIT_W'(val);
      REG_INTEGRAL_BAND: ctrl_cfg.integral_band = BAND_W'(val);
      REG_TURN_TOL:      ctrl_cfg.turn_tolerance = TOL_W'(val);
      REG_MIN_SPEED:     ctrl_cfg.min_speed = SPEED_W'(val);
      default: ;
    endcase
  endtask

  task automatic write_all(int kp, int ki, int kd, int lim, int band, int tol, int speed);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEGRAL_GAIN, ki);
    write_reg(REG_DERIV_GAIN, kd);
    write_reg(REG_CORR_LIMIT, lim);
    write_reg(REG_INTEGRAL_BAND, band);
    write_reg(REG_TURN_TOL, tol);
    write_reg(REG_MIN_SPEED, speed);
    settings_used++;
  endtask

  task automatic queue_req(heading_cmd_e c, int tgt, int cur);
    heading_req_t req;
    req.cmd = c;
    req.target = HEADING_W'(tgt);
    req.heading = HEADING_W'(cur);
    pending_reqs.push_back(req);
  endtask

  // small-error tracking runs are the largest share, so the window and integral stay busy
  task automatic load_random(int count);
    int roll;
    int cur;
    int tol;
    int err;
    int k;
    tol = int'(ctrl_cfg.turn_tolerance);
    for (k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (roll < 45) begin
        cur = $urandom_range(20, 319);
        queue_req(CMD_TRACK, cur + $urandom_range(0, 60) - 20, cur);
      end else if (roll < 60) begin
        queue_req(CMD_TRACK, $urandom_range(0, 511), $urandom_range(0, 511));
      end else if (roll < 80) begin
        queue_req(CMD_TURN, $urandom_range(0, 511), $urandom_range(0, 511));
      end else begin
        cur = $urandom_range(181, 330);
        err = $urandom_range(0, 2 * tol + 2) - tol - 1;
        queue_req(CMD_TURN, cur + err, cur);
      end
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_drive.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int phase;
    int i;
    ctrl_cfg = '{prop_gain: RST_PROP_GAIN, integral_gain_tenths: RST_INTEGRAL_GAIN,
                 deriv_gain: RST_DERIV_GAIN, correction_limit: RST_CORR_LIMIT,
                 integral_band: RST_INTEGRAL_BAND, turn_tolerance: RST_TURN_TOL,
                 min_speed: RST_MIN_SPEED};
    for (i = 0; i < WIN_DEPTH; i++) err_window[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // turn: tolerance edges, side boundaries, out-of-range headings
    queue_req(CMD_TURN, 0, 0);
    queue_req(CMD_TURN, 1, 0);
    queue_req(CMD_TURN, 2, 0);
    queue_req(CMD_TURN, 0, 1);
    queue_req(CMD_TURN, 179, 0);
    queue_req(CMD_TURN, 180, 0);
    queue_req(CMD_TURN, 0, 180);
    queue_req(CMD_TURN, 0, 181);
    queue_req(CMD_TURN, 511, 0);
    queue_req(CMD_TURN, 0, 511);
    queue_req(CMD_TURN, 511, 511);
    queue_req(CMD_TURN, 359, 0);
    // track: band edges, negative collapse, side boundaries, extremes
    queue_req(CMD_TRACK, 10, 10);
    queue_req(CMD_TRACK, 15, 10);
    queue_req(CMD_TRACK, 25, 10);
    queue_req(CMD_TRACK, 26, 10);
    queue_req(CMD_TRACK, 10, 15);
    queue_req(CMD_TRACK, 179, 0);
    queue_req(CMD_TRACK, 180, 0);
    queue_req(CMD_TRACK, 511, 0);
    queue_req(CMD_TRACK, 0, 511);
    queue_req(CMD_TRACK, 300, 290);
    queue_req(CMD_TRACK, 300, 295);
    drain();
    load_random(BATCH_ITEMS);
    drain();

    for (phase = 0; phase <= LAST_PHASE; phase++) begin
      case (phase)
        0: write_all(255, 255, 255, 450, 359, 180, 512);
        1: write_all(0, 0, 0, 0, 0, 0, 0);
        2: write_all(255, 255, 255, 511, 40, 1, 0);
        3, 6: write_all($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 450), $urandom_range(0, 359), $urandom_range(1, 180),
                        $urandom_range(0, 512));
        4: begin
          write_all($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 450), $urandom_range(0, 40), $urandom_range(1, 20),
                    $urandom_range(0, 512));
          steady_flow = 1'b1;
        end
        5: begin
          steady_flow = 1'b0;
          write_all(RST_PROP_GAIN, RST_INTEGRAL_GAIN, RST_DERIV_GAIN, RST_CORR_LIMIT,
                    RST_INTEGRAL_BAND, RST_TURN_TOL, RST_MIN_SPEED);
          write_reg(REG_UNUSED, $urandom_range(0, 1023));
        end
        default: ;
      endcase
      load_random(BATCH_ITEMS);
      drain();
    end

    $display("covered %0d turn and %0d track transactions (%0d aligned, %0d left side)",
             turns_sent, tracks_sent, aligned_seen, left_seen);
    $display("checked %0d results over %0d register settings, %0d mismatches",
             results_checked, settings_used, errors);
    if (errors == 0) begin
      $display("tb_heading_turn_and_track_pid_top: PASS");
    end else begin
      $display("tb_heading_turn_and_track_pid_top: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/htt_pkg.sv
rtl/core/htt_cfg.sv
rtl/core/htt_err.sv
rtl/core/htt_drv.sv
rtl/core/heading_turn_and_track_pid_top.sv
tb/tb_heading_turn_and_track_pid_top.sv
